### hdl/hc41_pkg.sv
`timescale 1ns / 1ps

package hc41_pkg;

    // Alphabet and group geometry
    localparam int SYM_COUNT  = 41;
    localparam int SYM_W      = 6;
    localparam int GROUP_SIZE = 3;
    localparam int KEY_ROW_W  = GROUP_SIZE * SYM_W;
    localparam int SUM_W      = 13;
    localparam int CHAR_W     = 8;

    // floor(2^16 / 41), used for the reciprocal step of the mod 41 reduction
    localparam int RECIP41    = 1598;
    localparam int PROD_W     = 24;

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_ROW_ZERO = 2'd0;
    localparam logic [1:0] CFG_KEY_ROW_ONE  = 2'd1;
    localparam logic [1:0] CFG_KEY_ROW_TWO  = 2'd2;

    // Reset key is the identity matrix
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_ZERO_RST = 18'd1;
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_ONE_RST  = 18'd64;
    localparam logic [KEY_ROW_W-1:0] KEY_ROW_TWO_RST  = 18'd4096;

    // ASCII codes of the alphabet landmarks
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_QUES  = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

    typedef logic [SYM_W-1:0] t_sym;

    typedef struct packed {
        logic [CHAR_W-1:0] in_char;
        logic              in_last;
    } t_in;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              out_last;
    } t_out;

    // One gathered group, entry j at bits 6j+5:6j
    typedef struct packed {
        t_sym [GROUP_SIZE-1:0] sym;
    } t_group;

    // Key matrix: row i, column j
    typedef struct packed {
        t_sym [GROUP_SIZE-1:0][GROUP_SIZE-1:0] k;
    } t_key;

    typedef struct packed {
        logic hit;
        t_sym idx;
    } t_lookup;

    // Map a byte to its alphabet index; hit is low for bytes outside it
    function automatic t_lookup sym_index(input logic [CHAR_W-1:0] c_in);
        logic [CHAR_W-1:0] c;
        t_lookup           res;
        c       = c_in;
        res.hit = 1'b1;
        res.idx = '0;
        if (c >= CH_LA && c <= CH_LZ) begin
            c = c - CASE_GAP;
        end
        if (c == CH_SPACE) begin
            res.idx = t_sym'(0);
        end else if (c >= CH_A && c <= CH_Z) begin
            res.idx = t_sym'(c - CH_A + 8'd1);
        end else if (c >= CH_0 && c <= CH_9) begin
            res.idx = t_sym'(c - CH_0 + 8'd27);
        end else if (c == CH_DOT) begin
            res.idx = t_sym'(37);
        end else if (c == CH_QUES) begin
            res.idx = t_sym'(38);
        end else if (c == CH_COMMA) begin
            res.idx = t_sym'(39);
        end else if (c == CH_DASH) begin
            res.idx = t_sym'(40);
        end else begin
            res.hit = 1'b0;
        end
        return res;
    endfunction

    // ASCII code of an alphabet index (0..40)
    function automatic logic [CHAR_W-1:0] sym_char(input t_sym idx);
        logic [CHAR_W-1:0] res;
        res = CH_DASH;
        if (idx == t_sym'(0)) begin
            res = CH_SPACE;
        end else if (idx <= t_sym'(26)) begin
            res = CH_A + CHAR_W'(idx) - 8'd1;
        end else if (idx <= t_sym'(36)) begin
            res = CH_0 + CHAR_W'(idx) - 8'd27;
        end else begin
            case (idx)
                t_sym'(37): res = CH_DOT;
                t_sym'(38): res = CH_QUES;
                t_sym'(39): res = CH_COMMA;
                default:    res = CH_DASH;
            endcase
        end
        return res;
    endfunction

    // Reduce a sum mod 41: the reciprocal estimate is floor or one below,
    // so one conditional subtract finishes it
    function automatic t_sym mod41(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        logic [7:0]        q;
        logic [SUM_W-1:0]  r;
        prod = PROD_W'(s) * PROD_W'(RECIP41);
        q    = prod[PROD_W-1:16];
        r    = s - SUM_W'(q) * SUM_W'(SYM_COUNT);
        if (r >= SUM_W'(SYM_COUNT)) begin
            r = r - SUM_W'(SYM_COUNT);
        end
        return t_sym'(r);
    endfunction

endpackage

### hdl/hc41_gather.sv
`timescale 1ns / 1ps

module hc41_gather (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  hc41_pkg::t_in i_in_data,
    output logic          o_grp_valid,
    input  logic          i_grp_ready,
    output hc41_pkg::t_group o_grp
);
    import hc41_pkg::*;

    logic [1:0] r_fill, n_fill;
    t_sym       r_sym0, r_sym1;
    logic       r_grp_valid, n_grp_valid;
    t_group     r_grp, n_grp;

    t_lookup    lk;
    logic       accept;
    logic [1:0] fill_after;
    logic       full;
    logic       emit;

    // Take a word whenever the group register is free or draining
    assign o_in_ready = !r_grp_valid || i_grp_ready;
    assign accept     = i_in_valid && o_in_ready;

    // Classify the byte and work out where the group stands
    always_comb begin
        lk         = sym_index(i_in_data.in_char);
        fill_after = r_fill + {1'b0, lk.hit};
        full       = (r_fill == 2'd2) && lk.hit;
        emit       = full || (i_in_data.in_last && (fill_after != 2'd0));
    end

    // Build the padded group and the next control state
    always_comb begin
        n_fill      = r_fill;
        n_grp_valid = r_grp_valid && !i_grp_ready;
        n_grp       = r_grp;
        if (accept) begin
            n_fill = emit ? 2'd0 : fill_after;
            if (emit) begin
                n_grp_valid = 1'b1;
                n_grp.sym[0] = (r_fill == 2'd0) ? lk.idx : r_sym0;
                n_grp.sym[1] = (fill_after >= 2'd2 || full) ?
                               ((r_fill == 2'd1) ? lk.idx : r_sym1) : t_sym'(0);
                n_grp.sym[2] = full ? lk.idx : t_sym'(0);
            end
        end
    end

    // Hold gathered symbols
    always_ff @(posedge i_clk) begin
        if (accept && lk.hit && !emit) begin
            if (r_fill == 2'd0) begin
                r_sym0 <= lk.idx;
            end else begin
                r_sym1 <= lk.idx;
            end
        end
        r_grp <= n_grp;
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 2'd0;
            r_grp_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_grp_valid <= n_grp_valid;
        end
    end

    assign o_grp_valid = r_grp_valid;
    assign o_grp       = r_grp;

endmodule

### hdl/hc41_mix.sv
`timescale 1ns / 1ps

module hc41_mix (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hc41_pkg::t_key   i_key,
    input  logic             i_grp_valid,
    output logic             o_grp_ready,
    input  hc41_pkg::t_group i_grp,
    output logic             o_mix_valid,
    input  logic             i_mix_ready,
    output logic [hc41_pkg::GROUP_SIZE-1:0][hc41_pkg::CHAR_W-1:0] o_chars
);
    import hc41_pkg::*;

    logic                                r_sum_valid, n_sum_valid;
    logic [GROUP_SIZE-1:0][SUM_W-1:0]    r_sum, n_sum;

    assign o_grp_ready = !r_sum_valid || i_mix_ready;

    // Row dot products: key row times the group vector
    always_comb begin
        for (int i = 0; i < GROUP_SIZE; i++) begin
            n_sum[i] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                n_sum[i] = n_sum[i] + SUM_W'(i_key.k[i][j]) * SUM_W'(i_grp.sym[j]);
            end
        end
    end

    always_comb begin
        n_sum_valid = r_sum_valid && !i_mix_ready;
        if (i_grp_valid && o_grp_ready) begin
            n_sum_valid = 1'b1;
        end
    end

    // Hold the sums
    always_ff @(posedge i_clk) begin
        if (i_grp_valid && o_grp_ready) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else begin
            r_sum_valid <= n_sum_valid;
        end
    end

    // Reduce mod 41 and map back to ASCII
    always_comb begin
        for (int i = 0; i < GROUP_SIZE; i++) begin
            o_chars[i] = sym_char(mod41(r_sum[i]));
        end
    end

    assign o_mix_valid = r_sum_valid;

endmodule

### hdl/hc41_serial.sv
`timescale 1ns / 1ps

module hc41_serial (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mix_valid,
    output logic           o_mix_ready,
    input  logic [hc41_pkg::GROUP_SIZE-1:0][hc41_pkg::CHAR_W-1:0] i_chars,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output hc41_pkg::t_out o_out_data
);
    import hc41_pkg::*;

    logic [GROUP_SIZE-1:0][CHAR_W-1:0] r_chars;
    logic [1:0]                        r_cnt, n_cnt;
    logic                              r_valid, n_valid;
    logic                              at_end;
    logic                              load;

    assign at_end      = (r_cnt == 2'(GROUP_SIZE - 1));
    assign o_mix_ready = !r_valid || (at_end && i_out_ready);
    assign load        = i_mix_valid && o_mix_ready;

    // Step through the three characters of a group
    always_comb begin
        n_cnt   = r_cnt;
        n_valid = r_valid;
        if (r_valid && i_out_ready) begin
            if (at_end) begin
                n_valid = 1'b0;
            end else begin
                n_cnt = r_cnt + 2'd1;
            end
        end
        if (load) begin
            n_valid = 1'b1;
            n_cnt   = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_chars <= i_chars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    assign o_out_valid         = r_valid;
    assign o_out_data.out_char = r_chars[r_cnt];
    assign o_out_data.out_last = at_end;

endmodule

### hdl/hill_cipher_3x3_mod41.sv
`timescale 1ns / 1ps

// Hill cipher over a 41-symbol alphabet (space, A-Z, 0-9, . ? , -) with a
// 3x3 key. Message bytes come in one word at a time; lower case is folded,
// bytes outside the alphabet are dropped, and every three symbols (or a
// partial group padded with spaces when in_last is set) produce three cipher
// words, the third marked with out_last. Load the inverse key to decrypt.
// Key rows must be written through the cfg port while the block is idle;
// the block itself does not enforce this. Reset loads the identity. A byte
// is accepted every cycle while groups gather and the group register is
// free or draining; each group goes out one word per cycle while out_ready
// is high, so the serializer sets the sustained rate: one byte per cycle for
// full groups, and only as fast as groups drain when each byte closes one.
// The first cipher word of a group passes the group, sum and output registers.
module hill_cipher_3x3_mod41 (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hc41_pkg::t_in                  i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hc41_pkg::t_out                 o_out_data,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [hc41_pkg::KEY_ROW_W-1:0] i_cfg_data
);
    import hc41_pkg::*;

    t_key   r_key;
    logic   grp_valid, grp_ready;
    t_group grp;
    logic   mix_valid, mix_ready;
    logic [GROUP_SIZE-1:0][CHAR_W-1:0] mix_chars;

    // Key rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.k[0] <= KEY_ROW_ZERO_RST;
            r_key.k[1] <= KEY_ROW_ONE_RST;
            r_key.k[2] <= KEY_ROW_TWO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_ROW_ZERO: r_key.k[0] <= i_cfg_data;
                CFG_KEY_ROW_ONE:  r_key.k[1] <= i_cfg_data;
                CFG_KEY_ROW_TWO:  r_key.k[2] <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    hc41_gather u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready),
        .o_grp       (grp)
    );

    hc41_mix u_mix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key       (r_key),
        .i_grp_valid (grp_valid),
        .o_grp_ready (grp_ready),
        .i_grp       (grp),
        .o_mix_valid (mix_valid),
        .i_mix_ready (mix_ready),
        .o_chars     (mix_chars)
    );

    hc41_serial u_serial (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mix_valid (mix_valid),
        .o_mix_ready (mix_ready),
        .i_chars     (mix_chars),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTH
    // Every cipher word is an alphabet symbol
    a_out_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.out_char == CH_SPACE) ||
            (o_out_data.out_char >= CH_A && o_out_data.out_char <= CH_Z) ||
            (o_out_data.out_char >= CH_0 && o_out_data.out_char <= CH_9) ||
            (o_out_data.out_char == CH_DOT) || (o_out_data.out_char == CH_QUES) ||
            (o_out_data.out_char == CH_COMMA) || (o_out_data.out_char == CH_DASH))
        else $error("cipher word outside the alphabet");

    // A group never breaks off before its last word
    a_group_whole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !o_out_data.out_last) |=> o_out_valid)
        else $error("group ended without a last word");

    // Input stalls only when the output holds a word
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");
`endif

endmodule
